/* src/ckd_pkg.sv */
// Shared types, key codes and chord lookup tables of the chord keyboard decoder.
`timescale 1ns / 1ps

package ckd_pkg;

   localparam int unsigned NumButtons = 7;
   localparam int unsigned MaxEvents  = 6;
   localparam int unsigned CountBits  = 3;

   // Chords with a special meaning
   localparam logic [NumButtons-1:0] ChordFar     = 7'h40;
   localparam logic [NumButtons-1:0] ChordNear    = 7'h10;
   localparam logic [NumButtons-1:0] ChordNumLock = 7'h1F;

   // Key codes
   localparam logic [7:0] CodeShift   = 8'h81;
   localparam logic [7:0] CodeLeft    = 8'hD8;
   localparam logic [7:0] CodeSpace   = 8'h20;
   localparam logic [7:0] CodeZero    = 8'h30;
   localparam logic [7:0] CodeLParen  = 8'h28;
   localparam logic [7:0] CodeRParen  = 8'h29;
   localparam logic [7:0] CodeDQuote  = 8'h22;
   localparam logic [7:0] CodeNone    = 8'h00;

   // Macro codes
   localparam logic [7:0] MacroZeros3 = 8'hE0;
   localparam logic [7:0] MacroZeros2 = 8'hE1;
   localparam logic [7:0] MacroParens = 8'hE2;
   localparam logic [7:0] MacroQuotes = 8'hE3;
   localparam logic [7:0] MacroBase   = 8'hE0;

   typedef struct packed {
      logic [7:0] key_code;
      logic       is_press;
   } event_type;

   function automatic logic [7:0] alpha_code(input logic [NumButtons-1:0] chord);
      logic [7:0] code;
      case (chord)
         7'd1:    code = 8'h77; // w
         7'd2:    code = 8'h79; // y
         7'd3:    code = 8'h75; // u
         7'd4:    code = 8'h72; // r
         7'd6:    code = 8'h68; // h
         7'd7:    code = 8'h73; // s
         7'd8:    code = 8'h69; // i
         7'd9:    code = 8'h62; // b
         7'd10:   code = 8'h6B; // k
         7'd11:   code = 8'h7A; // z
         7'd12:   code = 8'h64; // d
         7'd14:   code = 8'h65; // e
         7'd15:   code = 8'h74; // t
         7'd32:   code = 8'h20; // space
         7'd33:   code = 8'h66; // f
         7'd34:   code = 8'h67; // g
         7'd35:   code = 8'h76; // v
         7'd36:   code = 8'h63; // c
         7'd37:   code = 8'h5D; // ]
         7'd38:   code = 8'h70; // p
         7'd39:   code = 8'h6E; // n
         7'd40:   code = 8'h6C; // l
         7'd42:   code = 8'h6A; // j
         7'd43:   code = 8'h71; // q
         7'd44:   code = 8'h6D; // m
         7'd45:   code = 8'h5B; // [
         7'd46:   code = 8'h61; // a
         7'd47:   code = 8'h6F; // o
         7'd65:   code = 8'hB0; // return
         7'd66:   code = 8'hD7; // right
         7'd67:   code = 8'hD9; // down
         7'd68:   code = 8'hB2; // backspace
         7'd70:   code = 8'hD4; // delete
         7'd71:   code = 8'hD6; // page down
         7'd72:   code = 8'hD8; // left
         7'd73:   code = 8'hD5; // end
         7'd74:   code = 8'hB3; // tab
         7'd75:   code = 8'hD2; // home
         7'd76:   code = 8'hDA; // up
         7'd78:   code = 8'hD3; // page up
         7'd79:   code = 8'hC1; // caps lock
         default: code = CodeNone;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] number_code(input logic [NumButtons-1:0] chord);
      logic [7:0] code;
      case (chord)
         7'd1:    code = 8'h35; // 5
         7'd2:    code = 8'h34; // 4
         7'd3:    code = MacroQuotes;
         7'd4:    code = 8'h33; // 3
         7'd6:    code = MacroZeros2;
         7'd7:    code = 8'h2D; // -
         7'd8:    code = 8'h32; // 2
         7'd9:    code = 8'h5C; // backslash
         7'd10:   code = 8'h24; // $
         7'd11:   code = 8'h60; // backtick
         7'd12:   code = 8'h2F; // /
         7'd14:   code = 8'h3D; // =
         7'd15:   code = MacroZeros3;
         7'd32:   code = 8'h31; // 1
         7'd33:   code = 8'h39; // 9
         7'd34:   code = 8'h38; // 8
         7'd35:   code = 8'h5D; // ]
         7'd36:   code = 8'h37; // 7
         7'd37:   code = 8'h5D; // ]
         7'd38:   code = 8'h25; // %
         7'd39:   code = 8'h5B; // [
         7'd40:   code = 8'h36; // 6
         7'd42:   code = MacroParens;
         7'd43:   code = 8'h3F; // ?
         7'd44:   code = 8'h2A; // *
         7'd45:   code = 8'h5B; // [
         7'd46:   code = 8'h2B; // +
         7'd47:   code = 8'h30; // 0
         default: code = CodeNone;
      endcase
      return code;
   endfunction

endpackage

/* src/chord_keyboard_decoder_unit.sv */
// Top level of the chord keyboard decoder: edge detection, chord decode and event queue.
`timescale 1ns / 1ps

// Each accepted item is one tick of seven active-low button levels. The tick
// is decoded in the cycle it is accepted: press edges build the chord, a
// release edge closes it, and the chord either toggles a mode (shift once,
// number once, number lock; turning number once off also sends a space) or
// becomes a list of zero to six key events that is loaded into an event
// queue. The queue head drives the rsp_ ports directly, one event per cycle
// while rsp_stall is low, and rsp_last_event marks the final event of a tick.
// A new tick is accepted only while the queue is empty or in the same cycle
// the last queued event leaves, so a tick is never taken before the events
// of the one before it have drained.
// A tick with no events leaves no result at all.
module chord_keyboard_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_far_level,
   input  logic       req_center_level,
   input  logic       req_near_level,
   input  logic       req_index_level,
   input  logic       req_middle_level,
   input  logic       req_ring_level,
   input  logic       req_pinky_level,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_key_code,
   output logic       rsp_is_press,
   output logic       rsp_last_event
);

   localparam int unsigned NB = ckd_pkg::NumButtons;
   localparam int unsigned NE = ckd_pkg::MaxEvents;
   localparam int unsigned CB = ckd_pkg::CountBits;

   // Decoder state
   logic [NB-1:0] prev_levels_ff, prev_levels_in;
   logic [NB-1:0] chord_ff, chord_in;
   logic          shift_once_ff, shift_once_in;
   logic          number_once_ff, number_once_in;
   logic          number_lock_ff, number_lock_in;

   // Event queue, head at entry 0
   ckd_pkg::event_type queue_ff [NE];
   ckd_pkg::event_type queue_in [NE];
   logic [CB-1:0]      count_ff, count_in;

   logic req_take, rsp_take;

   // Decode signals
   logic [NB-1:0]      levels, pressed, released, chord_now;
   logic [7:0]         lookup;
   logic               send_key, send_macro, shift_wrap;
   logic [7:0]         key;
   logic [1:0]         taps;
   logic [7:0]         tap_code [3];
   ckd_pkg::event_type ev_list [NE];
   logic [CB-1:0]      ev_count;

   assign rsp_take  = rsp_valid && !rsp_stall;
   // Accept when the queue will be empty at this edge
   assign req_stall = (count_ff > CB'(1)) || ((count_ff == CB'(1)) && rsp_stall);
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid      = (count_ff != '0);
   assign rsp_key_code   = queue_ff[0].key_code;
   assign rsp_is_press   = queue_ff[0].is_press;
   assign rsp_last_event = (count_ff == CB'(1));

   assign levels = {req_far_level, req_center_level, req_near_level, req_index_level,
                    req_middle_level, req_ring_level, req_pinky_level};
   assign pressed   = prev_levels_ff & ~levels;
   assign released  = levels & ~prev_levels_ff;
   assign chord_now = chord_ff | pressed;

   // Number table when either number mode is active, alpha table otherwise
   assign lookup = (number_once_ff || number_lock_ff) ? ckd_pkg::number_code(chord_now)
                                                      : ckd_pkg::alpha_code(chord_now);

   // Decide mode changes and what to send for this tick
   always_comb begin
      prev_levels_in = levels;
      chord_in       = chord_now;
      shift_once_in  = shift_once_ff;
      number_once_in = number_once_ff;
      number_lock_in = number_lock_ff;
      send_key       = 1'b0;
      send_macro     = 1'b0;
      key            = lookup;
      if (released != '0) begin
         chord_in = '0;
         if (chord_now == ckd_pkg::ChordFar) begin
            shift_once_in = ~shift_once_ff;
         end else if (chord_now == ckd_pkg::ChordNear) begin
            number_once_in = ~number_once_ff;
            if (number_once_ff) begin
               send_key = 1'b1;
               key      = ckd_pkg::CodeSpace;
            end
         end else if (chord_now == ckd_pkg::ChordNumLock) begin
            number_lock_in = ~number_lock_ff;
         end else if (lookup >= ckd_pkg::MacroBase) begin
            send_macro = 1'b1;
         end else begin
            send_key = 1'b1;
         end
         // An ordinary key consumes both one-shot modes
         if (send_key) begin
            number_once_in = 1'b0;
            shift_once_in  = 1'b0;
         end
      end
   end

   assign shift_wrap = send_key && shift_once_ff;

   // Expand into up to three taps
   always_comb begin
      taps        = 2'd0;
      tap_code[0] = key;
      tap_code[1] = key;
      tap_code[2] = ckd_pkg::CodeLeft;
      if (send_key) begin
         taps = 2'd1;
      end else if (send_macro) begin
         case (lookup)
            ckd_pkg::MacroZeros3: begin
               taps        = 2'd3;
               tap_code[0] = ckd_pkg::CodeZero;
               tap_code[1] = ckd_pkg::CodeZero;
               tap_code[2] = ckd_pkg::CodeZero;
            end
            ckd_pkg::MacroZeros2: begin
               taps        = 2'd2;
               tap_code[0] = ckd_pkg::CodeZero;
               tap_code[1] = ckd_pkg::CodeZero;
            end
            ckd_pkg::MacroParens: begin
               taps        = 2'd3;
               tap_code[0] = ckd_pkg::CodeLParen;
               tap_code[1] = ckd_pkg::CodeRParen;
            end
            ckd_pkg::MacroQuotes: begin
               taps        = 2'd3;
               tap_code[0] = ckd_pkg::CodeDQuote;
               tap_code[1] = ckd_pkg::CodeDQuote;
            end
            default: begin
               taps = 2'd0;
            end
         endcase
      end
   end

   // Lay the taps out as press/release pairs, shift-wrapped when needed
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ev_list[2*k]   = '{key_code: tap_code[k], is_press: 1'b1};
         ev_list[2*k+1] = '{key_code: tap_code[k], is_press: 1'b0};
      end
      ev_count = {taps, 1'b0};
      if (shift_wrap) begin
         ev_list[0] = '{key_code: ckd_pkg::CodeShift, is_press: 1'b1};
         ev_list[1] = '{key_code: key, is_press: 1'b1};
         ev_list[2] = '{key_code: key, is_press: 1'b0};
         ev_list[3] = '{key_code: ckd_pkg::CodeShift, is_press: 1'b0};
         ev_count   = CB'(4);
      end
   end

   // Queue: load on accept, else advance on each event taken
   always_comb begin
      queue_in = queue_ff;
      count_in = count_ff;
      if (req_take) begin
         queue_in = ev_list;
         count_in = ev_count;
      end else if (rsp_take) begin
         for (int k = 0; k < NE - 1; k++) begin
            queue_in[k] = queue_ff[k+1];
         end
         count_in = count_ff - CB'(1);
      end
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_levels_ff <= '1;
         chord_ff       <= '0;
         shift_once_ff  <= 1'b0;
         number_once_ff <= 1'b0;
         number_lock_ff <= 1'b0;
         count_ff       <= '0;
      end else begin
         count_ff <= count_in;
         if (req_take) begin
            prev_levels_ff <= prev_levels_in;
            chord_ff       <= chord_in;
            shift_once_ff  <= shift_once_in;
            number_once_ff <= number_once_in;
            number_lock_ff <= number_lock_in;
         end
      end
   end

endmodule

/* dv/chord_keyboard_decoder_unit_test.sv */
// Self-checking testbench of the chord keyboard decoder: directed chords, random chords, stalls.
`timescale 1ns / 1ps

module chord_keyboard_decoder_unit_test;

   localparam int HalfPeriod     = 10;
   localparam int ResetCycles    = 6;
   localparam int BurstMax       = 6;
   localparam int LongHoldCycles = 100;
   localparam int DrainSlack     = 16;
   localparam int IdleLimit      = 2000;
   localparam int RandomTicks    = 130;
   localparam int PhaseTicks     = 35;

   localparam logic [6:0] AllReleased = 7'h7F;

   // Chords used by the directed tests
   localparam logic [6:0] ChordCapsLock   = 7'h4F;
   localparam logic [6:0] ChordAllButtons = 7'h7F;
   localparam logic [6:0] ChordLetterT    = 7'h0F;  // three zeros in number mode
   localparam logic [6:0] ChordLetterD    = 7'h0C;
   localparam logic [6:0] ChordMiddle     = 7'h04;
   localparam logic [6:0] ChordQuotes     = 7'h03;
   localparam logic [6:0] ChordZeros2     = 7'h06;
   localparam logic [6:0] ChordParens     = 7'h2A;

   // Key code tables, one row of 16 per value of chord[6:4]; rows not listed are unmapped
   localparam logic [0:15][7:0] AlphaRow0 = {
      8'h00, 8'h77, 8'h79, 8'h75, 8'h72, 8'h00, 8'h68, 8'h73,
      8'h69, 8'h62, 8'h6B, 8'h7A, 8'h64, 8'h00, 8'h65, 8'h74};
   localparam logic [0:15][7:0] AlphaRow2 = {
      8'h20, 8'h66, 8'h67, 8'h76, 8'h63, 8'h5D, 8'h70, 8'h6E,
      8'h6C, 8'h00, 8'h6A, 8'h71, 8'h6D, 8'h5B, 8'h61, 8'h6F};
   localparam logic [0:15][7:0] AlphaRow4 = {
      8'h00, 8'hB0, 8'hD7, 8'hD9, 8'hB2, 8'h00, 8'hD4, 8'hD6,
      8'hD8, 8'hD5, 8'hB3, 8'hD2, 8'hDA, 8'h00, 8'hD3, 8'hC1};
   localparam logic [0:15][7:0] NumberRow0 = {
      8'h00, 8'h35, 8'h34, 8'hE3, 8'h33, 8'h00, 8'hE1, 8'h2D,
      8'h32, 8'h5C, 8'h24, 8'h60, 8'h2F, 8'h00, 8'h3D, 8'hE0};
   localparam logic [0:15][7:0] NumberRow2 = {
      8'h31, 8'h39, 8'h38, 8'h5D, 8'h37, 8'h5D, 8'h25, 8'h5B,
      8'h36, 8'h00, 8'hE2, 8'h3F, 8'h2A, 8'h5B, 8'h2B, 8'h30};

   typedef struct packed {
      logic [7:0] key_code;
      logic       is_press;
      logic       last_event;
   } key_event_type;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic       req_far_level    = 1'b1;
   logic       req_center_level = 1'b1;
   logic       req_near_level   = 1'b1;
   logic       req_index_level  = 1'b1;
   logic       req_middle_level = 1'b1;
   logic       req_ring_level   = 1'b1;
   logic       req_pinky_level  = 1'b1;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic [7:0] rsp_key_code;
   logic       rsp_is_press;
   logic       rsp_last_event;

   // Predicted decoder state
   logic [6:0] prev_levels   = AllReleased;
   logic [6:0] chord_acc     = '0;
   bit         shift_pending = 1'b0;
   bit         num_once      = 1'b0;
   bit         num_lock      = 1'b0;

   key_event_type key_events_due[$];   // key events predicted and not yet seen
   key_event_type tick_events[$];      // key events of the tick being predicted

   // Idling controls, changed by the tests
   int gap_max       = 0;
   int stall_pct     = 0;
   int burst_left    = 0;
   bit long_hold_req = 1'b0;
   int hold_left     = 0;

   int fail_count      = 0;
   int ticks_sent      = 0;
   int events_checked  = 0;
   int shift_toggles   = 0;
   int once_toggles    = 0;
   int lock_toggles    = 0;
   int macros_expanded = 0;
   int idle_cycles     = 0;

   chord_keyboard_decoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_far_level    (req_far_level),
      .req_center_level (req_center_level),
      .req_near_level   (req_near_level),
      .req_index_level  (req_index_level),
      .req_middle_level (req_middle_level),
      .req_ring_level   (req_ring_level),
      .req_pinky_level  (req_pinky_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_code     (rsp_key_code),
      .rsp_is_press     (rsp_is_press),
      .rsp_last_event   (rsp_last_event)
   );

   always #HalfPeriod clock = ~clock;

   // ---------------------------------------------------------------------------
   // Key code lookup
   // ---------------------------------------------------------------------------
   function automatic logic [7:0] alpha_key(input logic [6:0] chord);
      case (chord[6:4])
         3'd0:    return AlphaRow0[chord[3:0]];
         3'd2:    return AlphaRow2[chord[3:0]];
         3'd4:    return AlphaRow4[chord[3:0]];
         default: return ckd_pkg::CodeNone;
      endcase
   endfunction

   function automatic logic [7:0] number_key(input logic [6:0] chord);
      case (chord[6:4])
         3'd0:    return NumberRow0[chord[3:0]];
         3'd2:    return NumberRow2[chord[3:0]];
         default: return ckd_pkg::CodeNone;
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Event prediction
   // ---------------------------------------------------------------------------
   task automatic add_event(input logic [7:0] code, input logic press);
      key_event_type ev;
      ev.key_code   = code;
      ev.is_press   = press;
      ev.last_event = 1'b0;
      tick_events.push_back(ev);
   endtask

   task automatic add_tap(input logic [7:0] code);
      add_event(code, 1'b1);
      add_event(code, 1'b0);
   endtask

   // Ordinary key: wrap in shift when a one-shot shift is pending, and drop both one-shots
   task automatic add_plain_key(input logic [7:0] code);
      bit wrapped;
      wrapped = shift_pending;
      if (wrapped)
         add_event(ckd_pkg::CodeShift, 1'b1);
      num_once = 1'b0;
      add_tap(code);
      if (wrapped) begin
         add_event(ckd_pkg::CodeShift, 1'b0);
         shift_pending = 1'b0;
      end
   endtask

   // Macros leave both one-shots alone and are never shifted
   task automatic add_macro(input logic [7:0] code);
      macros_expanded++;
      case (code)
         ckd_pkg::MacroZeros3: repeat (3) add_tap(ckd_pkg::CodeZero);
         ckd_pkg::MacroZeros2: repeat (2) add_tap(ckd_pkg::CodeZero);
         ckd_pkg::MacroParens: begin
            add_tap(ckd_pkg::CodeLParen);
            add_tap(ckd_pkg::CodeRParen);
            add_tap(ckd_pkg::CodeLeft);
         end
         ckd_pkg::MacroQuotes: begin
            add_tap(ckd_pkg::CodeDQuote);
            add_tap(ckd_pkg::CodeDQuote);
            add_tap(ckd_pkg::CodeLeft);
         end
         default: ;
      endcase
   endtask

   // Advance the predicted state by one tick and queue the key events it causes
   task automatic predict_tick(input logic [6:0] levels);
      logic [6:0] pressed;
      logic [6:0] released;
      logic [6:0] chord;
      logic [7:0] code;
      key_event_type ev;
      pressed     = prev_levels & ~levels;
      released    = levels & ~prev_levels;
      chord_acc   = chord_acc | pressed;
      prev_levels = levels;
      tick_events.delete();
      if (released != '0) begin
         // Any release closes the chord, including one already closed (empty chord)
         chord     = chord_acc;
         chord_acc = '0;
         if (chord == ckd_pkg::ChordFar) begin
            shift_pending = ~shift_pending;
            shift_toggles++;
         end else if (chord == ckd_pkg::ChordNear) begin
            once_toggles++;
            if (num_once) begin
               num_once = 1'b0;
               add_plain_key(ckd_pkg::CodeSpace);
            end else begin
               num_once = 1'b1;
            end
         end else if (chord == ckd_pkg::ChordNumLock) begin
            num_lock = ~num_lock;
            lock_toggles++;
         end else begin
            code = (num_once || num_lock) ? number_key(chord) : alpha_key(chord);
            if (code >= ckd_pkg::MacroBase)
               add_macro(code);
            else
               add_plain_key(code);
         end
         if (tick_events.size() != 0) begin
            ev = tick_events.pop_back();
            ev.last_event = 1'b1;
            tick_events.push_back(ev);
         end
         foreach (tick_events[i])
            key_events_due.push_back(tick_events[i]);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Sender: one tick per call, in bursts with random gaps between them
   // ---------------------------------------------------------------------------
   task automatic send_tick(input logic [6:0] levels);
      req_valid        <= 1'b1;
      req_far_level    <= levels[6];
      req_center_level <= levels[5];
      req_near_level   <= levels[4];
      req_index_level  <= levels[3];
      req_middle_level <= levels[2];
      req_ring_level   <= levels[1];
      req_pinky_level  <= levels[0];
      do
         @(posedge clock);
      while (req_stall);
      predict_tick(levels);
      ticks_sent++;
      // Close the burst with a gap when gap_max is nonzero; valid stays high inside a burst
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, BurstMax);
         if (gap_max != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Drop valid and hold the sender until every predicted event has come out
   task automatic wait_all_delivered();
      if (req_valid)
         req_valid <= 1'b0;
      while (key_events_due.size() != 0)
         @(posedge clock);
      repeat (DrainSlack) @(posedge clock);
   endtask

   // Play a whole chord from all buttons released: optional staggered press,
   // full press, then release (optionally split so a second, empty chord follows)
   task automatic play_chord(input logic [6:0] chord, input bit staggered,
                             input bit split_release);
      logic [6:0] partial;
      if (prev_levels != AllReleased)
         send_tick(AllReleased);
      if (staggered) begin
         partial = chord & 7'($urandom());
         if (partial != '0 && partial != chord)
            send_tick(~partial);
      end
      send_tick(~chord);
      if (split_release) begin
         partial = chord & 7'($urandom());
         if (partial != '0 && partial != chord)
            send_tick(~partial);
      end
      send_tick(AllReleased);
   endtask

   function automatic logic [6:0] random_chord();
      int pick;
      logic [2:0] row;
      logic [6:0] chord;
      pick = $urandom_range(99);
      if (pick < 10)
         return ckd_pkg::ChordFar;
      if (pick < 20)
         return ckd_pkg::ChordNear;
      if (pick < 25)
         return ckd_pkg::ChordNumLock;
      if (pick < 85) begin
         // Favor the mapped rows of the tables
         case ($urandom_range(2))
            0:       row = 3'd0;
            1:       row = 3'd2;
            default: row = 3'd4;
         endcase
         chord = {row, 4'($urandom())};
      end else begin
         chord = 7'($urandom());
      end
      return (chord == '0) ? ChordMiddle : chord;
   endfunction

   // ---------------------------------------------------------------------------
   // Receiver stall pattern; a long hold-off is counted here when requested
   // ---------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LongHoldCycles - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result checker: compare each accepted event with the oldest prediction
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : check_event
      key_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (key_events_due.size() == 0) begin
            $error("unexpected key event: key_code %02h is_press %0b", rsp_key_code,
                   rsp_is_press);
            fail_count++;
         end else begin
            want = key_events_due.pop_front();
            events_checked++;
            if (rsp_key_code !== want.key_code) begin
               $error("key_code: expected %02h, actual %02h", want.key_code, rsp_key_code);
               fail_count++;
            end
            if (rsp_is_press !== want.is_press) begin
               $error("is_press: expected %0b, actual %0b", want.is_press, rsp_is_press);
               fail_count++;
            end
            if (rsp_last_event !== want.last_event) begin
               $error("last_event: expected %0b, actual %0b", want.last_event,
                      rsp_last_event);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IdleLimit) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Special-key row and the all-buttons chord, which is unmapped
   task automatic test_alpha_extremes();
      gap_max   = 3;
      stall_pct = 30;
      play_chord(ChordCapsLock, 1'b0, 1'b0);
      play_chord(ChordAllButtons, 1'b0, 1'b0);
   endtask

   // One-shot shift wraps the next letter in shift press and release
   task automatic test_shift_once();
      play_chord(ckd_pkg::ChordFar, 1'b0, 1'b0);
      play_chord(ChordLetterT, 1'b0, 1'b0);
   endtask

   // Number once: a macro keeps the mode, the second near chord turns it off with a space
   task automatic test_number_once();
      play_chord(ckd_pkg::ChordNear, 1'b0, 1'b0);
      play_chord(ChordLetterT, 1'b0, 1'b0);
      play_chord(ckd_pkg::ChordNear, 1'b0, 1'b0);
   endtask

   // Number lock on, the remaining macros, number lock off
   task automatic test_number_lock_macros();
      play_chord(ckd_pkg::ChordNumLock, 1'b0, 1'b0);
      play_chord(ChordParens, 1'b0, 1'b0);
      play_chord(ChordQuotes, 1'b0, 1'b0);
      play_chord(ChordZeros2, 1'b0, 1'b0);
      play_chord(ckd_pkg::ChordNumLock, 1'b0, 1'b0);
   endtask

   // Partial release closes the chord; the later release decodes the empty chord
   task automatic test_empty_chord();
      send_tick(~ChordLetterD);
      send_tick(~ChordMiddle);
      send_tick(AllReleased);
   endtask

   // Mostly well-formed chords with random content, some raw noise ticks;
   // idling changes from phase to phase, with one stretch of none
   task automatic test_random_chords();
      int start;
      int done;
      start = ticks_sent;
      done  = 0;
      while (done < RandomTicks) begin
         case (done / PhaseTicks)
            0: begin
               gap_max   = 4;
               stall_pct = 30;
            end
            1: begin
               gap_max   = 0;
               stall_pct = 0;
            end
            2: begin
               gap_max   = 8;
               stall_pct = 60;
            end
            default: begin
               gap_max   = 2;
               stall_pct = 15;
            end
         endcase
         if ($urandom_range(99) < 20)
            send_tick(7'($urandom()));
         else
            play_chord(random_chord(), 1'($urandom_range(1)), $urandom_range(3) == 0);
         done = ticks_sent - start;
      end
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering ticks
   task automatic test_backpressure();
      gap_max       = 0;
      stall_pct     = 0;
      long_hold_req = 1'b1;
      repeat (12)
         play_chord({3'd2, 4'($urandom())}, 1'b0, 1'b0);
   endtask

   // Sender pauses until every pending event has drained, several times over
   task automatic test_drain_pause();
      gap_max   = 3;
      stall_pct = 40;
      repeat (3) begin
         repeat (3)
            play_chord(random_chord(), 1'b0, 1'b0);
         wait_all_delivered();
      end
   endtask

   initial begin
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      test_alpha_extremes();
      test_shift_once();
      test_number_once();
      test_number_lock_macros();
      test_empty_chord();
      test_random_chords();
      test_backpressure();
      test_drain_pause();
      wait_all_delivered();

      $display("Decoded %0d ticks into %0d checked key events, %0d mismatches.",
               ticks_sent, events_checked, fail_count);
      $display("Toggles: shift %0d, number once %0d, number lock %0d; macros %0d.",
               shift_toggles, once_toggles, lock_toggles, macros_expanded);
      if (fail_count == 0 && key_events_due.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* sim.f */
src/ckd_pkg.sv
src/chord_keyboard_decoder_unit.sv
dv/chord_keyboard_decoder_unit_test.sv
